>>> hdl/mts_pkg.sv
// ----------------------------------------------------------------------------
// Minimum-tracking stack package
// Shared widths, payload structs, operation and error codes, cell commands.
// ----------------------------------------------------------------------------
package mts_pkg;

   localparam int DEPTH       = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [COUNT_WIDTH-1:0]        count_type;

   localparam logic [1:0] FUNC_PUSH = 2'd0;
   localparam logic [1:0] FUNC_POP  = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
   localparam logic [1:0] ERR_UNDERFLOW = 2'd2;

   localparam count_type DEPTH_COUNT = COUNT_WIDTH'(DEPTH);
   localparam value_type EMPTY_VALUE = '1;

   typedef enum logic [1:0] {
      SHIFT_HOLD,
      SHIFT_PUSH,
      SHIFT_POP
   } shift_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      value_type  push_value;
   } req_type;

   typedef struct packed {
      value_type  top_value;
      value_type  min_value;
      logic       empty_flag;
      count_type  entry_count;
      logic [1:0] error_code;
   } rsp_type;

endpackage

>>> hdl/min_tracking_stack.sv
// ----------------------------------------------------------------------------
// Minimum-tracking stack
// LIFO stack of signed values with a second stack of running minima. Each
// operation returns top, minimum, empty flag, count and error code.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake            Payload
//   req_     in         req_valid/req_ready  req_data (func, push_value)
//   rsp_     out        rsp_valid/rsp_ready  rsp_data (top, min, empty, count, error)
//
// One operation per cycle: the shift chains move all entries in the cycle of
// the transfer, and the result is registered for the following cycle.
// A new request is taken while the result register is empty or being drained.
// Reset clears both counts and the result valid; chain contents stay unknown.
// A stalled result holds the request side off until it is taken.
// ----------------------------------------------------------------------------
module min_tracking_stack (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mts_pkg::rsp_type rsp_data
);
   import mts_pkg::*;

   count_type     value_count_ff, value_count_in;
   count_type     min_count_ff, min_count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;
   shift_cmd_type value_cmd, min_cmd;
   value_type     value_top, value_second, min_top, min_second;
   value_type     next_top, next_min;
   logic          accept;
   logic          do_push, do_pop, min_push, min_pop;
   logic [1:0]    error_code;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   mts_chain u_value_chain (
      .clock        (clock),
      .cmd          (value_cmd),
      .push_value   (req_data.push_value),
      .top_value    (value_top),
      .second_value (value_second)
   );

   mts_chain u_min_chain (
      .clock        (clock),
      .cmd          (min_cmd),
      .push_value   (req_data.push_value),
      .top_value    (min_top),
      .second_value (min_second)
   );

   always_comb begin
      do_push    = 1'b0;
      do_pop     = 1'b0;
      min_push   = 1'b0;
      min_pop    = 1'b0;
      error_code = ERR_NONE;
      case (req_data.func)
         FUNC_PUSH: begin
            if (value_count_ff == DEPTH_COUNT) begin
               error_code = ERR_OVERFLOW;
            end else begin
               do_push  = 1'b1;
               min_push = (min_count_ff != DEPTH_COUNT) &&
                          ((min_count_ff == '0) || (req_data.push_value <= min_top));
            end
         end
         FUNC_POP: begin
            if (value_count_ff == '0) begin
               error_code = ERR_UNDERFLOW;
            end else begin
               do_pop  = 1'b1;
               min_pop = (min_count_ff != '0) && (min_top == value_top);
            end
         end
         default: begin
         end
      endcase

      value_cmd = SHIFT_HOLD;
      min_cmd   = SHIFT_HOLD;
      if (accept) begin
         if (do_push) value_cmd = SHIFT_PUSH;
         if (do_pop)  value_cmd = SHIFT_POP;
         if (min_push) min_cmd = SHIFT_PUSH;
         if (min_pop)  min_cmd = SHIFT_POP;
      end

      value_count_in = value_count_ff;
      min_count_in   = min_count_ff;
      if (do_push)  value_count_in = value_count_ff + count_type'(1);
      if (do_pop)   value_count_in = value_count_ff - count_type'(1);
      if (min_push) min_count_in   = min_count_ff + count_type'(1);
      if (min_pop)  min_count_in   = min_count_ff - count_type'(1);

      if (do_push)     next_top = req_data.push_value;
      else if (do_pop) next_top = value_second;
      else             next_top = value_top;

      if (min_count_in == '0) next_min = EMPTY_VALUE;
      else if (min_push)      next_min = req_data.push_value;
      else if (min_pop)       next_min = min_second;
      else                    next_min = min_top;

      rsp_data_in.empty_flag  = (value_count_in == '0);
      rsp_data_in.top_value   = rsp_data_in.empty_flag ? EMPTY_VALUE : next_top;
      rsp_data_in.min_value   = rsp_data_in.empty_flag ? EMPTY_VALUE : next_min;
      rsp_data_in.entry_count = value_count_in;
      rsp_data_in.error_code  = error_code;

      rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_count_ff <= '0;
         min_count_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            value_count_ff <= value_count_in;
            min_count_ff   <= min_count_in;
         end
      end
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_min_not_above_count: assert property (@(posedge clock) disable iff (reset)
      min_count_ff <= value_count_ff)
      else $error("minimum count exceeds entry count");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      value_count_ff <= DEPTH_COUNT)
      else $error("entry count beyond depth");

   a_result_follows_transfer: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && (rsp_data_ff.entry_count == value_count_ff))
      else $error("result missing or count mismatch after transfer");

   a_error_keeps_count: assert property (@(posedge clock) disable iff (reset)
      accept && (error_code != ERR_NONE) |=> $stable(value_count_ff))
      else $error("count changed on an errored operation");

endmodule

>>> hdl/mts_cell.sv
// ----------------------------------------------------------------------------
// Minimum-tracking stack cell
// One stack entry. On a push it takes the entry above it, on a pop the one
// below it, otherwise it holds.
// ----------------------------------------------------------------------------
module mts_cell (
   input  logic                  clock,
   input  mts_pkg::shift_cmd_type cmd,
   input  mts_pkg::value_type    upper_value,
   input  mts_pkg::value_type    lower_value,
   output mts_pkg::value_type    value
);
   import mts_pkg::*;

   value_type value_ff;
   value_type value_in;

   always_comb begin
      case (cmd)
         SHIFT_PUSH: value_in = upper_value;
         SHIFT_POP:  value_in = lower_value;
         default:    value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

>>> hdl/mts_chain.sv
// ----------------------------------------------------------------------------
// Minimum-tracking stack chain
// A row of cells forming a shift stack; the first cell is the top.
// ----------------------------------------------------------------------------
module mts_chain (
   input  logic                   clock,
   input  mts_pkg::shift_cmd_type cmd,
   input  mts_pkg::value_type     push_value,
   output mts_pkg::value_type     top_value,
   output mts_pkg::value_type     second_value
);
   import mts_pkg::*;

   value_type cell_value [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      value_type upper_value;
      value_type lower_value;

      if (i == 0) begin : g_first
         assign upper_value = push_value;
      end else begin : g_inner_upper
         assign upper_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign lower_value = cell_value[i];
      end else begin : g_inner_lower
         assign lower_value = cell_value[i+1];
      end

      mts_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .upper_value (upper_value),
         .lower_value (lower_value),
         .value       (cell_value[i])
      );
   end

   assign top_value    = cell_value[0];
   assign second_value = cell_value[1];

endmodule

>>> verif/min_tracking_stack_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Minimum-tracking stack testbench
// Drives push, pop and read transfers into the stack and keeps a shadow copy
// of the value stack and the minima stack. Every response is compared field
// by field with the shadow view. The run covers the empty, full and
// overflow cases and extreme values. Stalls on both channels vary over three
// phases, and one long response hold fills the block.
// ----------------------------------------------------------------------------
module min_tracking_stack_tb;
   import mts_pkg::*;

   localparam logic [1:0] FUNC_UNUSED     = 2'd3;
   localparam int         HALF_PERIOD     = 4;
   localparam int         RESET_CYCLES    = 6;
   localparam int         RSP_HOLD_CYCLES = 300;
   localparam int         DRAIN_CYCLES    = 8;
   localparam int         TIMEOUT_NS      = 3_200_000;
   localparam int         PRINT_LIMIT     = 40;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   value_type shadow_values [DEPTH];
   value_type shadow_minima [DEPTH];
   int        shadow_depth     = 0;
   int        shadow_min_depth = 0;
   rsp_type   stack_snapshots [$];

   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        hold_requests = 0;
   int        holds_served  = 0;
   int        hold_left     = 0;
   value_type descend_base  = '0;

   int        mismatch_count  = 0;
   int        ops_sent        = 0;
   int        overflows_seen  = 0;
   int        underflows_seen = 0;
   int        full_reached    = 0;
   int        responses_seen  = 0;

   min_tracking_stack DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic rsp_type apply_stack_op(req_type op);
      rsp_type view;
      view.error_code = ERR_NONE;
      case (op.func)
         FUNC_PUSH: begin
            if (shadow_depth >= DEPTH) begin
               view.error_code = ERR_OVERFLOW;
            end else begin
               shadow_values[shadow_depth] = op.push_value;
               if (shadow_min_depth == 0 ||
                   $signed(op.push_value) <= $signed(shadow_minima[shadow_min_depth-1])) begin
                  shadow_minima[shadow_min_depth] = op.push_value;
                  shadow_min_depth++;
               end
               shadow_depth++;
            end
         end
         FUNC_POP: begin
            if (shadow_depth == 0) begin
               view.error_code = ERR_UNDERFLOW;
            end else begin
               shadow_depth--;
               if (shadow_min_depth > 0 &&
                   shadow_minima[shadow_min_depth-1] == shadow_values[shadow_depth])
                  shadow_min_depth--;
            end
         end
         default: begin
         end
      endcase
      if (shadow_depth == 0) begin
         view.top_value  = EMPTY_VALUE;
         view.min_value  = EMPTY_VALUE;
         view.empty_flag = 1'b1;
      end else begin
         view.top_value  = shadow_values[shadow_depth-1];
         view.min_value  = (shadow_min_depth > 0) ? shadow_minima[shadow_min_depth-1]
                                                  : EMPTY_VALUE;
         view.empty_flag = 1'b0;
      end
      view.entry_count = count_type'(shadow_depth);
      return view;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t: mismatch in %s: got %h, want %h", $realtime, field, got, want);
   endtask

   task automatic send_op(logic [1:0] func, value_type value);
      req_type item;
      rsp_type snap;
      item.func       = func;
      item.push_value = value;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      snap = apply_stack_op(item);
      stack_snapshots.insert(stack_snapshots.size(), snap);
      ops_sent++;
      if (snap.error_code == ERR_OVERFLOW) overflows_seen++;
      if (snap.error_code == ERR_UNDERFLOW) underflows_seen++;
      if (func == FUNC_PUSH && snap.error_code == ERR_NONE && shadow_depth == DEPTH)
         full_reached++;
   endtask

   function automatic value_type random_value();
      value_type v;
      case ($urandom_range(3))
         0: v = value_type'($urandom());
         1: v = value_type'(int'($urandom_range(8)) - 4);
         2: begin
            case ($urandom_range(4))
               0: v = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
               1: v = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
               2: v = '1;
               3: v = '0;
               default: v = value_type'(1);
            endcase
         end
         default: begin
            descend_base = descend_base - value_type'($urandom_range(3));
            v = descend_base;
         end
      endcase
      return v;
   endfunction

   task automatic test_empty_stack();
      send_op(FUNC_READ, '0);
      send_op(FUNC_POP, '1);
      send_op(FUNC_UNUSED, '1);
      send_op(FUNC_POP, '0);
   endtask

   task automatic test_extreme_values();
      value_type max_value;
      value_type min_value;
      max_value = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      min_value = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      send_op(FUNC_PUSH, max_value);
      send_op(FUNC_PUSH, max_value);
      send_op(FUNC_PUSH, min_value);
      send_op(FUNC_PUSH, '1);
      send_op(FUNC_PUSH, '0);
      send_op(FUNC_PUSH, min_value);
      send_op(FUNC_READ, max_value);
      send_op(FUNC_UNUSED, min_value);
      repeat (6) send_op(FUNC_POP, max_value);
      send_op(FUNC_POP, min_value);
      send_op(FUNC_READ, '1);
   endtask

   task automatic test_fill_and_overflow();
      repeat (DEPTH) send_op(FUNC_PUSH, random_value());
      send_op(FUNC_PUSH, random_value());
      send_op(FUNC_PUSH, random_value());
      send_op(FUNC_READ, random_value());
      send_op(FUNC_UNUSED, random_value());
      repeat (DEPTH) send_op(FUNC_POP, random_value());
      send_op(FUNC_POP, random_value());
   endtask

   task automatic test_random_ops(int count);
      int sent;
      int run;
      int kind;
      logic [1:0] func;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(9);
         run  = (kind <= 6) ? $urandom_range(1, 70) : $urandom_range(1, 20);
         if (run > count - sent) run = count - sent;
         repeat (run) begin
            if (kind <= 3)
               func = FUNC_PUSH;
            else if (kind <= 6)
               func = FUNC_POP;
            else if (kind <= 8)
               func = ($urandom_range(9) < 8) ?
                      (($urandom_range(1) == 0) ? FUNC_PUSH : FUNC_POP) :
                      (($urandom_range(1) == 0) ? FUNC_READ : FUNC_UNUSED);
            else
               func = 2'($urandom_range(3));
            send_op(func, (kind == 9) ? value_type'($urandom()) : random_value());
         end
         sent += run;
      end
   endtask

   task automatic test_response_backpressure();
      int saved_idle;
      saved_idle    = send_idle_pct;
      send_idle_pct = 0;
      hold_requests++;
      repeat (30) send_op(2'($urandom_range(2)), random_value());
      send_idle_pct = saved_idle;
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (holds_served != hold_requests) begin
            if (hold_left == 0) hold_left = RSP_HOLD_CYCLES;
            rsp_ready <= 1'b0;
            hold_left--;
            if (hold_left == 0) holds_served++;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (stack_snapshots.size() == 0) begin
            report_mismatch("response with nothing pending", rsp_data.top_value, '0);
         end else begin
            want = stack_snapshots.pop_front();
            if (rsp_data.top_value !== want.top_value)
               report_mismatch("top_value", rsp_data.top_value, want.top_value);
            if (rsp_data.min_value !== want.min_value)
               report_mismatch("min_value", rsp_data.min_value, want.min_value);
            if (rsp_data.empty_flag !== want.empty_flag)
               report_mismatch("empty_flag", 32'(rsp_data.empty_flag),
                               32'(want.empty_flag));
            if (rsp_data.entry_count !== want.entry_count)
               report_mismatch("entry_count", 32'(rsp_data.entry_count),
                               32'(want.entry_count));
            if (rsp_data.error_code !== want.error_code)
               report_mismatch("error_code", 32'(rsp_data.error_code),
                               32'(want.error_code));
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timed out with %0d responses outstanding.", stack_snapshots.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 35;
      recv_idle_pct = 88;
      test_empty_stack();
      test_extreme_values();
      test_fill_and_overflow();
      test_random_ops(570);

      send_idle_pct = 88;
      recv_idle_pct = 35;
      test_random_ops(570);
      test_response_backpressure();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_ops(570);

      @(negedge clock);
      req_valid <= 1'b0;
      while (stack_snapshots.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d stack operations with %0d responses checked.", ops_sent,
               responses_seen);
      $display("The stack filled %0d times, with %0d overflows and %0d underflows.",
               full_reached, overflows_seen, underflows_seen);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches found.", mismatch_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/mts_pkg.sv
hdl/mts_cell.sv
hdl/mts_chain.sv
hdl/min_tracking_stack.sv
verif/min_tracking_stack_tb.sv
